// File: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, widths and codes of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int unsigned CAPACITY = 1024;

  localparam int unsigned KEY_W = 21;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned STS_W = 2;
  localparam int unsigned OCC_W = 11;

  // Slot numbers run from 1 to CAPACITY, so a count must hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KID_W = CNT_W + 1;
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  typedef enum logic [STS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_RD_PARENT,
    OP_MOVE_UP,
    OP_PLACE,
    OP_LOAD_LAST,
    OP_RD_KIDS,
    OP_MOVE_DOWN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic parent_gt;
    logic kids_out;
    logic child_lt;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap memory, entry count, moving entry and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_datapath
  import bmhq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  output sts_t                         sts_o,
  input  wire logic                    action_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic [TAG_W-1:0]        tag_i,
  output logic [TAG_W-1:0]             out_tag_o,
  output logic signed [KEY_W-1:0]      out_key_o,
  output logic [STS_W-1:0]             status_o,
  output logic [OCC_W-1:0]             occupancy_o
);

  entry_t heap_mem [CAPACITY];

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  entry_t           mov_q, mov_d;
  entry_t           rd_a_q, rd_b_q;
  entry_t           res_q, res_d;
  status_e          res_sts_q, res_sts_d;

  entry_t           out_q;
  status_e          out_sts_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic [CNT_W-1:0] parent;
  logic [KID_W-1:0] kid_l, kid_r, child_slot;
  logic             right_ok, pick_r;
  entry_t           child;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] addr_a, addr_b, wr_addr;
  entry_t           wr_data;

  logic is_full, is_empty;

  assign is_full  = (count_q >= CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  assign parent = pos_q >> 1;
  assign kid_l  = {pos_q, 1'b0};
  assign kid_r  = {pos_q, 1'b1};

  // Ties between the children go to the left child.
  assign right_ok   = (kid_r <= {1'b0, count_q});
  assign pick_r     = right_ok && (rd_a_q.key > rd_b_q.key);
  assign child      = pick_r ? rd_b_q : rd_a_q;
  assign child_slot = pick_r ? kid_r : kid_l;

  assign sts_o.full      = is_full;
  assign sts_o.empty     = is_empty;
  assign sts_o.at_root   = (pos_q == CNT_W'(1));
  assign sts_o.parent_gt = (rd_a_q.key > mov_q.key);
  assign sts_o.kids_out  = (kid_l > {1'b0, count_q});
  assign sts_o.child_lt  = (child.key < mov_q.key);

  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    mov_d     = mov_q;
    res_d     = res_q;
    res_sts_d = res_sts_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    addr_a    = '0;
    addr_b    = '0;
    wr_addr   = IDX_W'(pos_q - CNT_W'(1));
    wr_data   = mov_q;
    unique case (cmd_i.op)
      OP_START: begin
        res_d = '0;
        if (action_i == ACT_INSERT) begin
          if (is_full) begin
            res_sts_d = ST_FULL;
          end else begin
            res_sts_d = ST_INSERTED;
            count_d   = count_q + CNT_W'(1);
            pos_d     = count_q + CNT_W'(1);
            mov_d.key = key_i;
            mov_d.tag = tag_i;
          end
        end else begin
          if (is_empty) begin
            res_sts_d = ST_EMPTY;
          end else begin
            // Fetch the root and the last entry together.
            res_sts_d = ST_REMOVED;
            count_d   = count_q - CNT_W'(1);
            rd_en     = 1'b1;
            addr_a    = '0;
            addr_b    = IDX_W'(count_q - CNT_W'(1));
          end
        end
      end
      OP_RD_PARENT: begin
        rd_en  = 1'b1;
        addr_a = IDX_W'(parent - CNT_W'(1));
      end
      OP_MOVE_UP: begin
        wr_en   = 1'b1;
        wr_data = rd_a_q;
        pos_d   = parent;
      end
      OP_PLACE: begin
        wr_en = 1'b1;
      end
      OP_LOAD_LAST: begin
        res_d = rd_a_q;
        mov_d = rd_b_q;
        pos_d = CNT_W'(1);
      end
      OP_RD_KIDS: begin
        rd_en  = 1'b1;
        addr_a = IDX_W'(kid_l - KID_W'(1));
        addr_b = IDX_W'(kid_r - KID_W'(1));
      end
      OP_MOVE_DOWN: begin
        wr_en   = 1'b1;
        wr_data = child;
        pos_d   = CNT_W'(child_slot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= heap_mem[addr_a];
      rd_b_q <= heap_mem[addr_b];
    end
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    mov_q     <= mov_d;
    res_q     <= res_d;
    res_sts_q <= res_sts_d;
    if (cmd_i.load_out) begin
      out_q     <= res_q;
      out_sts_q <= res_sts_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_tag_o   = out_q.tag;
  assign out_key_o   = out_q.key;
  assign status_o    = out_sts_q;
  assign occupancy_o = OCC_W'(out_cnt_q);

endmodule

`default_nettype wire

// File: rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer of the sift-up and sift-down walks and of the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic action_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHECK,
    S_DN_CMP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          if (action_i == ACT_INSERT) begin
            state_d = sts_i.full ? S_FINISH : S_UP_CHECK;
          end else begin
            state_d = sts_i.empty ? S_FINISH : S_DN_LOAD;
          end
        end
      end
      S_UP_CHECK: begin
        if (sts_i.at_root) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_RD_PARENT;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.parent_gt) begin
          cmd_o.op = OP_MOVE_UP;
          state_d  = S_UP_CHECK;
        end else begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FINISH;
        end
      end
      S_DN_LOAD: begin
        cmd_o.op = OP_LOAD_LAST;
        // The count already dropped; nothing is left to rebuild when it is zero.
        state_d  = sts_i.empty ? S_FINISH : S_DN_CHECK;
      end
      S_DN_CHECK: begin
        if (sts_i.kids_out) begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_RD_KIDS;
          state_d  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts_i.child_lt) begin
          cmd_o.op = OP_MOVE_DOWN;
          state_d  = S_DN_CHECK;
        end else begin
          cmd_o.op = OP_PLACE;
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of signed keys with tags, kept as a 1-based binary min-heap.
// ----------------------------------------------------------------------------
// Sequence, from the accepting edge to the edge that loads the result: an insert
// moves its entry up level by level until it reaches the root or a parent that is
// not greater, then places it; a remove loads the last entry into the root and moves
// it down until it reaches a leaf or no child is smaller, and skips the walk when it
// empties the heap. A refused insert or remove skips the walk as well. One transaction
// at a time is taken; reset clears the count and handshake state, not the heap memory.
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Request channel.
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    action_i,
  input  wire logic signed [KEY_W-1:0] key_i,
  input  wire logic [TAG_W-1:0]        tag_i,
  // Result channel.
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [TAG_W-1:0]             out_tag_o,
  output logic signed [KEY_W-1:0]      out_key_o,
  output logic [STS_W-1:0]             status_o,
  output logic [OCC_W-1:0]             occupancy_o
);

  // The controller walks the heap one level at a time, in a check state and a compare state, and tells the
  // datapath which read, move or placement to perform. The datapath reports
  // back the key comparisons and the boundary checks that steer the walk.
  // Reset clears the entry count and the handshake state; the heap memory is
  // not cleared, since only slots up to the count are ever used.
  cmd_t cmd;
  sts_t sts;

  // A new transaction is accepted in the idle state even while the previous
  // result is still waiting in the output register; the finish state holds
  // the new result back until that register is free.
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the heap memory with two registered read ports, so a
  // remove fetches root and last entry at once and sift-down reads both
  // children together. Insert on full and remove on empty change nothing
  // and report their status with a zero key and tag.
  bmhq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .out_tag_o   (out_tag_o),
    .out_key_o   (out_key_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire
